// ===== rtl/mjdg_pkg.sv =====
// Shared constants, tables and types for the MJD to Gregorian date converter.
`timescale 1ns / 1ps
`default_nettype none

package mjdg_pkg;

    localparam int MJD_W   = 32;
    localparam int YEAR_W  = 24;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int DOY_W   = 9;

    localparam longint DAYS_400Y   = 146097;
    localparam longint DAYS_CENT   = 36524;
    localparam longint DAYS_4Y     = 1461;
    localparam longint DAYS_YEAR   = 365;
    localparam longint MJD_MAR_2000 = 51604;
    localparam longint MAR_TO_JAN  = 306;
    localparam longint JAN_FEB_COMMON = 31 + 28;
    localparam longint JAN_FEB_LEAP   = 31 + 29;

    // Bias in whole 400-year cycles that makes every shifted day count non-negative.
    localparam longint CYC_BIAS   = 14700;
    localparam longint CYC_OFFSET = CYC_BIAS * DAYS_400Y - MJD_MAR_2000;
    localparam longint YEAR_BASE  = 2000 - CYC_BIAS * 400;

    localparam int E_W    = 33;
    localparam int Q_W    = 15;
    localparam int R_W    = 19;
    localparam int DAY_W  = 18;
    localparam int DAY2_W = 16;
    localparam int G_W    = 5;
    localparam int YR_W   = 9;
    localparam int DMAR_W = 9;

    // Estimate of the cycle count from the top bits of the biased day count.
    localparam int RECIP1_SHIFT = 48;
    localparam int E_DROP       = 8;
    localparam int RECIP1_W     = 31;
    localparam logic [RECIP1_W-1:0] RECIP_400Y =
        RECIP1_W'((64'd1 << RECIP1_SHIFT) / 64'(DAYS_400Y));

    // Exact quotient by 1461 for values below one century.
    localparam int RECIP2_SHIFT = 26;
    localparam logic [15:0] RECIP_4Y =
        16'(((64'd1 << RECIP2_SHIFT) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    localparam int NUM_MONTHS = 12;
    localparam logic [DMAR_W-1:0] MAR_MONTH_START [NUM_MONTHS] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
        logic [DOY_W-1:0]   day_of_year;
        logic               year_inc;
    } date_t;

endpackage

`default_nettype wire

// ===== rtl/mjdg_mjd_if.sv =====
// Channel carrying one Modified Julian Day number per item.
`timescale 1ns / 1ps
`default_nettype none

interface mjdg_mjd_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mjdg_pkg::MJD_W-1:0]       mjd;

    modport source (output valid, output mjd, input ready);
    modport sink   (input valid, input mjd, output ready);
endinterface

`default_nettype wire

// ===== rtl/mjdg_date_if.sv =====
// Channel carrying one Gregorian calendar date per item.
`timescale 1ns / 1ps
`default_nettype none

interface mjdg_date_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mjdg_pkg::YEAR_W-1:0]      year;
    logic        [mjdg_pkg::MONTH_W-1:0]     month;
    logic        [mjdg_pkg::DOM_W-1:0]       day_of_month;
    logic        [mjdg_pkg::DOY_W-1:0]       day_of_year;

    modport source (output valid, output year, output month, output day_of_month,
                     output day_of_year, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                     input day_of_year, output ready);
endinterface

`default_nettype wire

// ===== rtl/mjd_to_gregorian_date.sv =====
// Top level: pipelined Modified Julian Day to proleptic Gregorian date converter.
//
//   channel     dir   payload                                   role
//   mjd_item    in    mjd (s32)                                 day number
//   date_item   out   year (s24), month, day_of_month,          calendar date
//                     day_of_year
//
// Eight register stages, one item per cycle sustained while date_item is ready.
// The longest stage is the 25 x 31 bit reciprocal multiply that estimates the
// 400-year cycle count. Each stage has its own valid bit and holds only while
// the stage after it is full and stalled, so bubbles close up under back-pressure.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module mjd_to_gregorian_date (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mjdg_mjd_if.sink    mjd_item,
    mjdg_date_if.source date_item
);

    localparam int NST = 8;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;

    // stage registers
    logic [mjdg_pkg::E_W-1:0]          e1_reg, e2_reg;
    logic [mjdg_pkg::Q_W-1:0]          qest2_reg, qest3_reg, q4_reg;
    logic [mjdg_pkg::R_W-1:0]          r3_reg;
    logic [mjdg_pkg::DAY_W-1:0]        day4_reg;
    logic [mjdg_pkg::DAY2_W-1:0]       day2_5_reg, day2_6_reg;
    logic [1:0]                        c5_reg, c6_reg;
    logic                              lastc5_reg, lastc6_reg;
    logic [mjdg_pkg::YEAR_W-1:0]       yb5_reg, yb6_reg, yb7_reg;
    logic [mjdg_pkg::G_W-1:0]          g6_reg;
    logic [mjdg_pkg::YR_W-1:0]         yr7_reg;
    logic [mjdg_pkg::DMAR_W-1:0]       dmar7_reg;
    logic [mjdg_pkg::YEAR_W-1:0]       year8_reg;
    mjdg_pkg::date_t                   date8_reg;

    // next values
    logic [mjdg_pkg::E_W-1:0]          e1_next;
    logic [55:0]                       prod2;
    logic [mjdg_pkg::Q_W-1:0]          qest2_next;
    logic [mjdg_pkg::E_W-1:0]          qm3;
    logic [mjdg_pkg::E_W-1:0]          rfull3;
    logic [mjdg_pkg::R_W-1:0]          r3_next;
    logic [mjdg_pkg::Q_W-1:0]          q4_next;
    logic [mjdg_pkg::DAY_W-1:0]        day4_next;
    logic [1:0]                        c5_next;
    logic                              lastc5_next;
    logic [mjdg_pkg::DAY_W-1:0]        day2full5;
    logic [mjdg_pkg::DAY2_W-1:0]       day2_5_next;
    logic [mjdg_pkg::YEAR_W-1:0]       yb5_next;
    logic [31:0]                       prod6;
    logic [mjdg_pkg::G_W-1:0]          g6_next;
    logic [mjdg_pkg::DAY2_W-1:0]       day3full7;
    logic [10:0]                       day3_7;
    logic [1:0]                        y7;
    logic                              lastg7;
    logic [mjdg_pkg::YR_W-1:0]         yr7_next;
    logic [mjdg_pkg::DMAR_W-1:0]       dmar7_next;
    mjdg_pkg::date_t                   date8_next;
    logic [mjdg_pkg::YEAR_W-1:0]       year8_next;

    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || date_item.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign mjd_item.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= mjd_item.valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: bias the day count so it is never negative
    assign e1_next = {mjd_item.mjd[mjdg_pkg::MJD_W-1], mjd_item.mjd}
                     + mjdg_pkg::E_W'(mjdg_pkg::CYC_OFFSET);

    // stage 2: reciprocal estimate of the cycle count, low by at most two
    assign prod2      = 56'(e1_reg[mjdg_pkg::E_W-1:mjdg_pkg::E_DROP])
                        * 56'(mjdg_pkg::RECIP_400Y);
    assign qest2_next = prod2[mjdg_pkg::RECIP1_SHIFT - mjdg_pkg::E_DROP
                              + mjdg_pkg::Q_W - 1 :
                              mjdg_pkg::RECIP1_SHIFT - mjdg_pkg::E_DROP];

    // stage 3: remainder of the estimate
    assign qm3     = mjdg_pkg::E_W'(qest2_reg) * mjdg_pkg::E_W'(mjdg_pkg::DAYS_400Y);
    assign rfull3  = e2_reg - qm3;
    assign r3_next = rfull3[mjdg_pkg::R_W-1:0];

    // stage 4: fix up quotient and remainder
    always_comb
    begin
        priority if (r3_reg >= mjdg_pkg::R_W'(2 * mjdg_pkg::DAYS_400Y))
        begin
            q4_next   = qest3_reg + 15'd2;
            day4_next = mjdg_pkg::DAY_W'(r3_reg - mjdg_pkg::R_W'(2 * mjdg_pkg::DAYS_400Y));
        end
        else if (r3_reg >= mjdg_pkg::R_W'(mjdg_pkg::DAYS_400Y))
        begin
            q4_next   = qest3_reg + 15'd1;
            day4_next = mjdg_pkg::DAY_W'(r3_reg - mjdg_pkg::R_W'(mjdg_pkg::DAYS_400Y));
        end
        else
        begin
            q4_next   = qest3_reg;
            day4_next = mjdg_pkg::DAY_W'(r3_reg);
        end
    end

    // stage 5: centuries and year base of the cycle
    always_comb
    begin
        priority if (day4_reg >= mjdg_pkg::DAY_W'(3 * mjdg_pkg::DAYS_CENT))
        begin
            c5_next = 2'd3;
        end
        else if (day4_reg >= mjdg_pkg::DAY_W'(2 * mjdg_pkg::DAYS_CENT))
        begin
            c5_next = 2'd2;
        end
        else if (day4_reg >= mjdg_pkg::DAY_W'(mjdg_pkg::DAYS_CENT))
        begin
            c5_next = 2'd1;
        end
        else
        begin
            c5_next = 2'd0;
        end
    end

    assign lastc5_next = (day4_reg == mjdg_pkg::DAY_W'(mjdg_pkg::DAYS_400Y - 1));
    assign day2full5   = day4_reg
                         - mjdg_pkg::DAY_W'(c5_next) * mjdg_pkg::DAY_W'(mjdg_pkg::DAYS_CENT);
    assign day2_5_next = day2full5[mjdg_pkg::DAY2_W-1:0];
    assign yb5_next    = mjdg_pkg::YEAR_W'(mjdg_pkg::YEAR_BASE)
                         + mjdg_pkg::YEAR_W'(q4_reg) * 24'd400;

    // stage 6: 4-year groups
    assign prod6   = 32'(day2_5_reg) * 32'(mjdg_pkg::RECIP_4Y);
    assign g6_next = prod6[mjdg_pkg::RECIP2_SHIFT + mjdg_pkg::G_W - 1 : mjdg_pkg::RECIP2_SHIFT];

    // stage 7: years within the group, March-based day
    assign day3full7 = day2_6_reg
                       - mjdg_pkg::DAY2_W'(g6_reg) * mjdg_pkg::DAY2_W'(mjdg_pkg::DAYS_4Y);
    assign day3_7    = day3full7[10:0];
    assign lastg7    = (day3_7 == 11'(mjdg_pkg::DAYS_4Y - 1));

    always_comb
    begin
        priority if (day3_7 >= 11'(3 * mjdg_pkg::DAYS_YEAR))
        begin
            y7 = 2'd3;
        end
        else if (day3_7 >= 11'(2 * mjdg_pkg::DAYS_YEAR))
        begin
            y7 = 2'd2;
        end
        else if (day3_7 >= 11'(mjdg_pkg::DAYS_YEAR))
        begin
            y7 = 2'd1;
        end
        else
        begin
            y7 = 2'd0;
        end
    end

    always_comb
    begin
        priority if (lastc6_reg)
        begin
            yr7_next   = 9'd399;
            dmar7_next = 9'(mjdg_pkg::DAYS_YEAR);
        end
        else if (lastg7)
        begin
            yr7_next   = 9'(c6_reg) * 9'd100 + 9'({g6_reg, 2'b00}) + 9'd3;
            dmar7_next = 9'(mjdg_pkg::DAYS_YEAR);
        end
        else
        begin
            yr7_next   = 9'(c6_reg) * 9'd100 + 9'({g6_reg, 2'b00}) + 9'(y7);
            dmar7_next = 9'(day3_7 - 11'(y7) * 11'(mjdg_pkg::DAYS_YEAR));
        end
    end

    // stage 8: month table, January rebase, full year
    mjdg_march_date u_march_date (
        .dmar (dmar7_reg),
        .yr   (yr7_reg),
        .date (date8_next)
    );

    assign year8_next = yb7_reg + mjdg_pkg::YEAR_W'(yr7_reg)
                        + mjdg_pkg::YEAR_W'(date8_next.year_inc);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e1_reg <= e1_next;
        end
        if (adv[1])
        begin
            e2_reg    <= e1_reg;
            qest2_reg <= qest2_next;
        end
        if (adv[2])
        begin
            qest3_reg <= qest2_reg;
            r3_reg    <= r3_next;
        end
        if (adv[3])
        begin
            q4_reg   <= q4_next;
            day4_reg <= day4_next;
        end
        if (adv[4])
        begin
            c5_reg     <= c5_next;
            lastc5_reg <= lastc5_next;
            day2_5_reg <= day2_5_next;
            yb5_reg    <= yb5_next;
        end
        if (adv[5])
        begin
            c6_reg     <= c5_reg;
            lastc6_reg <= lastc5_reg;
            day2_6_reg <= day2_5_reg;
            yb6_reg    <= yb5_reg;
            g6_reg     <= g6_next;
        end
        if (adv[6])
        begin
            yr7_reg   <= yr7_next;
            dmar7_reg <= dmar7_next;
            yb7_reg   <= yb6_reg;
        end
        if (adv[7])
        begin
            year8_reg <= year8_next;
            date8_reg <= date8_next;
        end
    end

    assign date_item.valid        = vld_reg[NST-1];
    assign date_item.year         = year8_reg;
    assign date_item.month        = date8_reg.month;
    assign date_item.day_of_month = date8_reg.day_of_month;
    assign date_item.day_of_year  = date8_reg.day_of_year;

endmodule

`default_nettype wire

// ===== rtl/mjdg_march_date.sv =====
// March-based day to month, day of month and January-based day of year.
`timescale 1ns / 1ps
`default_nettype none

module mjdg_march_date (
    input  wire logic [mjdg_pkg::DMAR_W-1:0] dmar,
    input  wire logic [mjdg_pkg::YR_W-1:0]   yr,
    output mjdg_pkg::date_t                  date
);

    logic [3:0]                    mi;
    logic [mjdg_pkg::DMAR_W-1:0]   dom_full;
    logic                          common;

    always_comb
    begin
        mi = 4'd0;
        for (int k = 1; k < mjdg_pkg::NUM_MONTHS; k++)
        begin
            if (dmar >= mjdg_pkg::MAR_MONTH_START[k])
            begin
                mi = 4'(k);
            end
        end
    end

    assign dom_full = dmar - mjdg_pkg::MAR_MONTH_START[mi] + 9'd1;
    assign common   = (yr[1:0] != 2'd0) || (yr == 9'd100) || (yr == 9'd200)
                      || (yr == 9'd300);

    always_comb
    begin
        date.day_of_month = dom_full[mjdg_pkg::DOM_W-1:0];
        date.month        = (mi < 4'd10) ? mi + 4'd3 : mi - 4'd9;
        if (dmar >= 9'(mjdg_pkg::MAR_TO_JAN))
        begin
            date.year_inc    = 1'b1;
            date.day_of_year = dmar - 9'(mjdg_pkg::MAR_TO_JAN);
        end
        else
        begin
            date.year_inc    = 1'b0;
            date.day_of_year = dmar + (common ? 9'(mjdg_pkg::JAN_FEB_COMMON)
                                              : 9'(mjdg_pkg::JAN_FEB_LEAP));
        end
    end

endmodule

`default_nettype wire

// ===== dv/mjd_to_gregorian_date_tb.sv =====
// Self-checking testbench: random and corner-case MJD items against a date predictor.
`timescale 1ns / 1ps

module mjd_to_gregorian_date_tb;

    localparam longint ERA_DAYS      = 146097;
    localparam longint CENT_DAYS     = 36524;
    localparam longint QUAD_DAYS     = 1461;
    localparam longint YEAR_DAYS     = 365;
    localparam longint EPOCH_MAR_2000 = 51604;
    localparam longint MAR_TO_DEC    = 306;
    localparam int     NUM_RANDOM    = 1750;
    localparam int     MAX_REPORTS   = 10;
    localparam int     DRAIN_CYCLES  = 20;
    localparam int     MARCH_START [12] = '{0, 31, 61, 92, 122, 153,
                                            184, 214, 245, 275, 306, 337};

    typedef struct packed {
        logic signed [mjdg_pkg::YEAR_W-1:0] year;
        logic [mjdg_pkg::MONTH_W-1:0]       month;
        logic [mjdg_pkg::DOM_W-1:0]         day_of_month;
        logic [mjdg_pkg::DOY_W-1:0]         day_of_year;
    } gdate_t;

    typedef struct {
        logic signed [mjdg_pkg::MJD_W-1:0] mjd;
        gdate_t                            date;
    } date_expect_t;

    typedef struct {
        logic signed [mjdg_pkg::MJD_W-1:0] mjd;
        bit                                hold;
    } day_item_t;

    logic clk;
    logic rst_n;

    mjdg_mjd_if  mjd_ch ();
    mjdg_date_if date_ch ();

    mjd_to_gregorian_date DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .mjd_item  (mjd_ch),
        .date_item (date_ch)
    );

    day_item_t    days_pending [$];
    date_expect_t dates_expected [$];
    int           src_gap = 0;
    int           snk_gap = 0;
    bit           src_calm = 1'b0;
    bit           snk_calm = 1'b0;
    int           mismatches = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic gdate_t date_of_mjd(input logic signed [mjdg_pkg::MJD_W-1:0] mjd);
        longint off;
        longint era;
        longint yr;
        longint q;
        int     m;
        gdate_t g;
        off = longint'(mjd) - EPOCH_MAR_2000;
        era = off / ERA_DAYS;
        off = off % ERA_DAYS;
        if (off < 0)
        begin
            era = era - 1;
            off = off + ERA_DAYS;
        end
        if (off == ERA_DAYS - 1)
        begin
            yr  = 399;
            off = 365;
        end
        else
        begin
            q   = off / CENT_DAYS;
            yr  = q * 100;
            off = off - q * CENT_DAYS;
            q   = off / QUAD_DAYS;
            yr  = yr + q * 4;
            off = off - q * QUAD_DAYS;
            if (off == QUAD_DAYS - 1)
            begin
                yr  = yr + 3;
                off = 365;
            end
            else
            begin
                q   = off / YEAR_DAYS;
                yr  = yr + q;
                off = off - q * YEAR_DAYS;
            end
        end
        m = 11;
        while (m > 0 && off < MARCH_START[m])
            m--;
        g.day_of_month = mjdg_pkg::DOM_W'(off - MARCH_START[m] + 1);
        g.month        = mjdg_pkg::MONTH_W'(m >= 10 ? m - 9 : m + 3);
        // March-based day to January-based, carrying Jan/Feb into the next year
        if (off >= MAR_TO_DEC)
        begin
            yr  = yr + 1;
            off = off - MAR_TO_DEC;
        end
        else if (yr % 4 == 0 && yr != 100 && yr != 200 && yr != 300)
            off = off + 60;
        else
            off = off + 59;
        g.day_of_year = mjdg_pkg::DOY_W'(off);
        g.year        = mjdg_pkg::YEAR_W'(2000 + era * 400 + yr);
        return g;
    endfunction

    function automatic int gap_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_day(input longint day, input bit hold);
        days_pending.push_back('{mjd: mjdg_pkg::MJD_W'(day), hold: hold});
    endfunction

    // Mix of full-range words, dates near today and calendar boundaries in any era.
    function automatic longint random_mjd();
        int     kind;
        longint v;
        kind = $urandom_range(9);
        if (kind < 3)
            return longint'($signed($urandom()));
        if (kind < 6)
            return EPOCH_MAR_2000 - 100000 + longint'($urandom_range(200000));
        v = EPOCH_MAR_2000 + longint'(int'($urandom_range(29200)) - 14600) * ERA_DAYS
            + longint'($urandom_range(3)) * CENT_DAYS
            + longint'($urandom_range(24)) * QUAD_DAYS
            + longint'($urandom_range(3)) * YEAR_DAYS
            + longint'(int'($urandom_range(4)) - 2);
        if ($urandom_range(1) == 1)
            v = v + MARCH_START[$urandom_range(11)];
        return v;
    endfunction

    task automatic check_field(input string field,
                               input logic signed [mjdg_pkg::MJD_W-1:0] mjd,
                               input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mjd %0d: %s expected %0d, got %0d", mjd, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        day_item_t nxt;
        if (!rst_n)
        begin
            mjd_ch.valid <= 1'b0;
            mjd_ch.mjd   <= '0;
            src_gap      <= 0;
        end
        else
        begin
            if (mjd_ch.valid && mjd_ch.ready)
                dates_expected.push_back('{mjd: mjd_ch.mjd, date: date_of_mjd(mjd_ch.mjd)});
            if (!mjd_ch.valid || mjd_ch.ready)
            begin
                if (src_gap != 0)
                begin
                    mjd_ch.valid <= 1'b0;
                    src_gap      <= src_gap - 1;
                end
                else if (days_pending.size() != 0 &&
                         !(days_pending[0].hold && dates_expected.size() != 0))
                begin
                    nxt = days_pending.pop_front();
                    mjd_ch.valid <= 1'b1;
                    mjd_ch.mjd   <= nxt.mjd;
                    src_gap      <= gap_len(src_calm);
                end
                else
                    mjd_ch.valid <= 1'b0;
            end
            if ($urandom_range(149) == 0)
                src_calm <= !src_calm;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        date_expect_t want;
        if (!rst_n)
        begin
            date_ch.ready <= 1'b0;
            snk_gap       <= 0;
        end
        else
        begin
            if (date_ch.valid && date_ch.ready)
            begin
                if (dates_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected date item: year %0d month %0d day %0d",
                                 date_ch.year, date_ch.month, date_ch.day_of_month);
                end
                else
                begin
                    want = dates_expected.pop_front();
                    check_field("year", want.mjd, longint'(want.date.year),
                                longint'(date_ch.year));
                    check_field("month", want.mjd, longint'(want.date.month),
                                longint'(date_ch.month));
                    check_field("day_of_month", want.mjd, longint'(want.date.day_of_month),
                                longint'(date_ch.day_of_month));
                    check_field("day_of_year", want.mjd, longint'(want.date.day_of_year),
                                longint'(date_ch.day_of_year));
                end
            end
            if (snk_gap != 0)
            begin
                date_ch.ready <= 1'b0;
                snk_gap       <= snk_gap - 1;
            end
            else
            begin
                date_ch.ready <= 1'b1;
                snk_gap       <= gap_len(snk_calm);
            end
            if ($urandom_range(199) == 0)
                snk_calm <= !snk_calm;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;

        add_day(32'sh8000_0000, 1'b0);
        add_day(32'sh7FFF_FFFF, 1'b0);
        add_day(0, 1'b0);
        add_day(-1, 1'b0);
        add_day(1, 1'b0);
        add_day(EPOCH_MAR_2000 - 1, 1'b0);
        add_day(EPOCH_MAR_2000, 1'b0);
        add_day(EPOCH_MAR_2000 - ERA_DAYS - 1, 1'b0);
        add_day(EPOCH_MAR_2000 - ERA_DAYS, 1'b0);
        add_day(EPOCH_MAR_2000 + QUAD_DAYS - 2, 1'b0);
        add_day(EPOCH_MAR_2000 + QUAD_DAYS - 1, 1'b0);
        add_day(EPOCH_MAR_2000 + QUAD_DAYS, 1'b0);
        for (i = 1; i <= 3; i++)
        begin
            add_day(EPOCH_MAR_2000 + i * CENT_DAYS - 1, 1'b0);
            add_day(EPOCH_MAR_2000 + i * CENT_DAYS, 1'b0);
        end
        add_day(EPOCH_MAR_2000 + ERA_DAYS - 1, 1'b0);
        add_day(EPOCH_MAR_2000 + MAR_TO_DEC - 1, 1'b0);
        add_day(EPOCH_MAR_2000 + MAR_TO_DEC, 1'b0);
        add_day(EPOCH_MAR_2000 - 60, 1'b0);
        add_day(EPOCH_MAR_2000 + YEAR_DAYS + MAR_TO_DEC - 1, 1'b0);

        for (i = 0; i < NUM_RANDOM; i++)
            add_day(random_mjd(), i == 0 || $urandom_range(299) == 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (days_pending.size() != 0 || mjd_ch.valid || dates_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("mjd_to_gregorian_date test passed");
        else
            $display("mjd_to_gregorian_date test failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("mjd_to_gregorian_date test failed");
        $finish;
    end

endmodule

// ===== mjd_to_gregorian_date.f =====
rtl/mjdg_pkg.sv
rtl/mjdg_mjd_if.sv
rtl/mjdg_date_if.sv
rtl/mjdg_march_date.sv
rtl/mjd_to_gregorian_date.sv
dv/mjd_to_gregorian_date_tb.sv
